// ===== hw/rtl/ppf_pkg.sv =====
// Package for the position PID force controller.
// Holds field widths, fixed-point constants, payload types and register codes.
// No dependencies.
package ppf_pkg;

    // Gain fixed point: fraction bits of the signed gain registers
    localparam int GAIN_FRAC_BITS = 12;

    // Field widths
    localparam int POS_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int BAND_W     = 15;
    localparam int FORCE_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Datapath widths: exact products and their three-way sum
    localparam int PROD_W = GAIN_W + POS_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int QUO_W  = ACC_W - GAIN_FRAC_BITS;

    // Force clamp and truncation bias
    localparam int FORCE_LIMIT = 100;
    localparam logic signed [QUO_W-1:0] QUO_MAX = QUO_W'(FORCE_LIMIT);
    localparam logic signed [QUO_W-1:0] QUO_MIN = -QUO_W'(FORCE_LIMIT);
    localparam logic signed [ACC_W-1:0] TRUNC_BIAS =
        (ACC_W'(1) <<< GAIN_FRAC_BITS) - ACC_W'(1);

    // Register reset values
    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST      = 16'sd410;
    localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST     = 16'sd41;
    localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST     = 16'sd205;
    localparam logic        [BAND_W-1:0] DEAD_BAND_RST      = 15'd100;
    localparam logic        [BAND_W-1:0] INTEGRAL_LIMIT_RST = 15'd1000;

    // Payload types
    typedef logic signed [POS_W-1:0]      t_pos;
    typedef logic signed [GAIN_W-1:0]     t_gain;
    typedef logic        [BAND_W-1:0]     t_band;
    typedef logic signed [FORCE_W-1:0]    t_force;
    typedef logic        [CFG_IDX_W-1:0]  t_cfg_addr;
    typedef logic        [CFG_DATA_W-1:0] t_cfg_data;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN      = 3'd0,
        CFG_INTEG_GAIN     = 3'd1,
        CFG_DERIV_GAIN     = 3'd2,
        CFG_DEAD_BAND      = 3'd3,
        CFG_INTEGRAL_LIMIT = 3'd4
    } t_cfg_idx;

endpackage

// ===== hw/rtl/ppf_if.sv =====
// Handshake channels of the position PID force controller.
// Input item, result item and register write channels; depends on ppf_pkg.

interface ppf_in_if;
    logic          valid;
    logic          ready;
    ppf_pkg::t_pos measured_position;
    ppf_pkg::t_pos wanted_position;

    modport source (output valid, measured_position, wanted_position, input ready);
    modport sink   (input valid, measured_position, wanted_position, output ready);
endinterface

interface ppf_out_if;
    logic            valid;
    logic            ready;
    ppf_pkg::t_force drive_force;
    logic            in_dead_band;

    modport source (output valid, drive_force, in_dead_band, input ready);
    modport sink   (input valid, drive_force, in_dead_band, output ready);
endinterface

interface ppf_cfg_if;
    logic               valid;
    logic               ready;
    ppf_pkg::t_cfg_addr index;
    ppf_pkg::t_cfg_data data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pid_position_force.sv =====
// Position PID controller with dead band and anti-windup, giving a force percent.
// Four-stage elastic pipeline; depends on ppf_pkg and the channels in ppf_if.sv.
// Throughput: one item per cycle unless stalled; error state updates in stage 2.
// Each stage holds while the one after it is full and stalled, so items keep
// entering while a finished result waits. Register writes are taken every cycle.
// Reset (synchronous, active low) empties the pipeline, loads register defaults
// and clears the integral and previous error.
module pid_position_force (
    input  logic i_clk,
    input  logic i_rst_n,
    ppf_in_if.sink    i_in,
    ppf_out_if.source o_out,
    ppf_cfg_if.sink   i_cfg
);
    import ppf_pkg::*;

    // Configuration registers
    t_gain r_prop_gain, r_integ_gain, r_deriv_gain;
    t_band r_dead_band, r_integral_limit;

    // Controller state
    t_pos r_error_sum, r_last_error;

    // Pipeline registers
    logic  r_v1, r_v2, r_v3, r_out_valid;
    t_pos  r_meas, r_want;
    t_pos  r_s2_err, r_s2_sum, r_s2_deriv;
    logic  r_s2_db;
    logic signed [PROD_W-1:0] r_p_prop, r_p_integ, r_p_deriv;
    logic  r_s3_db;
    t_force r_out_force;
    logic  r_out_db;

    // Stage handshake
    logic rdy1, rdy2, rdy3, rdy4;
    logic adv1;
    logic gain_wr;

    // Stage 2 combinational
    t_pos                  e_err, e_deriv, e_sum;
    logic signed [POS_W:0] e_err_x, e_sum_raw, e_lim;
    logic        [POS_W:0] e_mag;
    logic                  e_hit;

    // Stage 4 combinational
    logic signed [ACC_W-1:0] a_acc, a_adj;
    logic signed [QUO_W-1:0] a_quo, a_clamp;

    // Elastic ready chain
    assign rdy4 = !r_out_valid || o_out.ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign adv1 = r_v1 && rdy2;

    assign i_in.ready  = rdy1;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid        = r_out_valid;
    assign o_out.drive_force  = r_out_force;
    assign o_out.in_dead_band = r_out_db;

    // Any gain write clears the state
    assign gain_wr = i_cfg.valid && (i_cfg.index == CFG_PROP_GAIN ||
                                     i_cfg.index == CFG_INTEG_GAIN ||
                                     i_cfg.index == CFG_DERIV_GAIN);

    // Error, dead band test, clamped integral and derivative
    always_comb begin
        e_err     = r_want - r_meas;
        e_err_x   = {e_err[POS_W-1], e_err};
        e_mag     = e_err[POS_W-1] ? unsigned'(-e_err_x) : unsigned'(e_err_x);
        e_hit     = e_mag < {2'b00, r_dead_band};
        e_lim     = signed'({2'b00, r_integral_limit});
        e_sum_raw = {r_error_sum[POS_W-1], r_error_sum} + e_err_x;
        if (e_sum_raw > e_lim) begin
            e_sum = e_lim[POS_W-1:0];
        end else if (e_sum_raw < -e_lim) begin
            e_sum = POS_W'(-e_lim);
        end else begin
            e_sum = e_sum_raw[POS_W-1:0];
        end
        e_deriv = e_err - r_last_error;
    end

    // Weighted sum, truncation toward zero, force clamp
    always_comb begin
        a_acc = ACC_W'(r_p_prop) + ACC_W'(r_p_integ) + ACC_W'(r_p_deriv);
        a_adj = a_acc[ACC_W-1] ? a_acc + TRUNC_BIAS : a_acc;
        a_quo = QUO_W'(a_adj >>> GAIN_FRAC_BITS);
        if (a_quo > QUO_MAX) begin
            a_clamp = QUO_MAX;
        end else if (a_quo < QUO_MIN) begin
            a_clamp = QUO_MIN;
        end else begin
            a_clamp = a_quo;
        end
    end

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain      <= PROP_GAIN_RST;
            r_integ_gain     <= INTEG_GAIN_RST;
            r_deriv_gain     <= DERIV_GAIN_RST;
            r_dead_band      <= DEAD_BAND_RST;
            r_integral_limit <= INTEGRAL_LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PROP_GAIN:      r_prop_gain      <= i_cfg.data;
                CFG_INTEG_GAIN:     r_integ_gain     <= i_cfg.data;
                CFG_DERIV_GAIN:     r_deriv_gain     <= i_cfg.data;
                CFG_DEAD_BAND:      r_dead_band      <= i_cfg.data[BAND_W-1:0];
                CFG_INTEGRAL_LIMIT: r_integral_limit <= i_cfg.data[BAND_W-1:0];
                default: ;
            endcase
        end
    end

    // Integral and previous error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || gain_wr) begin
            r_error_sum  <= '0;
            r_last_error <= '0;
        end else if (adv1) begin
            if (e_hit) begin
                r_error_sum  <= '0;
                r_last_error <= '0;
            end else begin
                r_error_sum  <= e_sum;
                r_last_error <= e_err;
            end
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy1) r_v1        <= i_in.valid;
            if (rdy2) r_v2        <= r_v1;
            if (rdy3) r_v3        <= r_v2;
            if (rdy4) r_out_valid <= r_v3;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (i_in.valid && rdy1) begin
            r_meas <= i_in.measured_position;
            r_want <= i_in.wanted_position;
        end
        if (adv1) begin
            r_s2_err   <= e_err;
            r_s2_sum   <= e_sum;
            r_s2_deriv <= e_deriv;
            r_s2_db    <= e_hit;
        end
        if (r_v2 && rdy3) begin
            r_p_prop  <= r_prop_gain  * r_s2_err;
            r_p_integ <= r_integ_gain * r_s2_sum;
            r_p_deriv <= r_deriv_gain * r_s2_deriv;
            r_s3_db   <= r_s2_db;
        end
        if (r_v3 && rdy4) begin
            r_out_force <= r_s3_db ? '0 : a_clamp[FORCE_W-1:0];
            r_out_db    <= r_s3_db;
        end
    end

    // A dead band result carries zero force
    a_db_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_db |-> r_out_force == '0)
        else $error("dead band result with nonzero force");

    // Force stays inside the clamp
    a_force_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_force <= 8'sd100 && r_out_force >= -8'sd100))
        else $error("force outside clamp");

    // A dead band item leaves the state cleared
    a_db_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv1 && e_hit |=> r_error_sum == '0 && r_last_error == '0)
        else $error("state not cleared after dead band item");

    // A gain write clears the state
    a_gain_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gain_wr |=> r_error_sum == '0 && r_last_error == '0)
        else $error("state not cleared after gain write");

    // The stored integral never exceeds the integral limit after a fresh clamp
    a_sum_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv1 && !e_hit && !gain_wr |=>
            (signed'({r_error_sum[POS_W-1], r_error_sum}) <=
             signed'({2'b00, $past(r_integral_limit)}))
        )
        else $error("integral above limit");

endmodule

// ===== dv/pid_position_force_test.sv =====
// Self-checking testbench for the position PID force controller.
// Drives the item and register channels, predicts each result, checks it field by field.
// Depends on ppf_pkg, the channels in ppf_if.sv and pid_position_force.
module pid_position_force_test;
    import ppf_pkg::*;

    // Run limits
    localparam int PIPE_LATENCY = 3;
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int MAX_WAIT     = 13;
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASES       = 10;

    // Register indexes that decode to no register
    localparam t_cfg_addr CFG_SPARE_LO = 3'd5;
    localparam t_cfg_addr CFG_SPARE_HI = 3'd7;

    // One expected result item
    typedef struct {
        t_force drive_force;
        logic   in_dead_band;
    } t_force_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ppf_in_if  in_ch ();
    ppf_out_if out_ch ();
    ppf_cfg_if cfg_ch ();

    pid_position_force DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #1 i_clk = ~i_clk;

    // Controller settings and loop state as the testbench sees them
    t_gain kp, ki, kd;
    t_band band, windup_limit;
    int    integ_acc;
    t_pos  prev_err;

    t_force_result pending_forces[$];

    // Bookkeeping
    int  mismatches;
    int  items_sent;
    int  results_seen;
    int  band_hits;
    int  reg_writes;
    int  cycle_count;
    int  send_gap_max;
    int  stall_max;
    int  hold_request;
    bit  offering;

    // Settings after reset
    task automatic reset_controller();
        kp           = PROP_GAIN_RST;
        ki           = INTEG_GAIN_RST;
        kd           = DERIV_GAIN_RST;
        band         = DEAD_BAND_RST;
        windup_limit = INTEGRAL_LIMIT_RST;
        integ_acc    = 0;
        prev_err     = '0;
    endtask

    // Register write side effects; gain writes restart the loop state
    task automatic apply_register(t_cfg_addr idx, t_cfg_data data);
        case (idx)
            CFG_PROP_GAIN: begin
                kp = t_gain'(data);
                integ_acc = 0;
                prev_err = '0;
            end
            CFG_INTEG_GAIN: begin
                ki = t_gain'(data);
                integ_acc = 0;
                prev_err = '0;
            end
            CFG_DERIV_GAIN: begin
                kd = t_gain'(data);
                integ_acc = 0;
                prev_err = '0;
            end
            CFG_DEAD_BAND:      band = data[BAND_W-1:0];
            CFG_INTEGRAL_LIMIT: windup_limit = data[BAND_W-1:0];
            default: ;
        endcase
    endtask

    // Force for one position pair; updates the integral and previous error
    function automatic t_force_result predict_force(t_pos meas, t_pos want);
        t_pos          err;
        t_pos          slope;
        int            mag;
        int            sum;
        longint        acc;
        longint        quo;
        t_force_result r;
        err = want - meas;
        mag = (err < 0) ? -int'(err) : int'(err);
        if (mag < int'(band)) begin
            integ_acc = 0;
            prev_err = '0;
            r.drive_force = '0;
            r.in_dead_band = 1'b1;
            return r;
        end
        // Anti-windup clamp on the running error sum
        sum = integ_acc + int'(err);
        if (sum > int'(windup_limit)) sum = int'(windup_limit);
        if (sum < -int'(windup_limit)) sum = -int'(windup_limit);
        integ_acc = sum;
        slope = err - prev_err;
        prev_err = err;
        acc = longint'(kp) * longint'(err) + longint'(ki) * longint'(sum)
            + longint'(kd) * longint'(slope);
        // Signed division truncates toward zero
        quo = acc / (longint'(1) << GAIN_FRAC_BITS);
        if (quo > FORCE_LIMIT) quo = FORCE_LIMIT;
        if (quo < -FORCE_LIMIT) quo = -FORCE_LIMIT;
        r.drive_force = t_force'(quo);
        r.in_dead_band = 1'b0;
        return r;
    endfunction

    // Offer one position item after a random gap and wait for its acceptance
    task automatic send_position(t_pos meas, t_pos want);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            if (offering) in_ch.valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.measured_position <= meas;
        in_ch.wanted_position <= want;
        offering = 1'b1;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        pending_forces.push_back(predict_force(meas, want));
        items_sent++;
    endtask

    // Stop offering and wait until every expected result has come
    task automatic drain_results();
        if (offering) in_ch.valid <= 1'b0;
        offering = 1'b0;
        while (pending_forces.size() != 0) @(posedge i_clk);
    endtask

    // Register write, only while the pipeline is empty
    task automatic cfg_write(t_cfg_addr idx, t_cfg_data data);
        drain_results();
        repeat (PIPE_LATENCY) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        apply_register(idx, data);
        reg_writes++;
    endtask

    // Compare one accepted result with the oldest expectation
    task automatic check_result(t_force drive_force, logic in_dead_band);
        t_force_result exp_r;
        results_seen++;
        if (pending_forces.size() == 0) begin
            $error("unexpected result: drive_force %0d in_dead_band %0b",
                   drive_force, in_dead_band);
            mismatches++;
            return;
        end
        exp_r = pending_forces.pop_front();
        if (exp_r.in_dead_band) band_hits++;
        if (drive_force !== exp_r.drive_force) begin
            $error("drive_force: expected %0d, got %0d", exp_r.drive_force, drive_force);
            mismatches++;
        end
        if (in_dead_band !== exp_r.in_dead_band) begin
            $error("in_dead_band: expected %0b, got %0b", exp_r.in_dead_band, in_dead_band);
            mismatches++;
        end
    endtask

    // Result receiver: random stalls, plus a long hold-off on request
    initial begin : result_sink
        int stall;
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end else begin
                stall = $urandom_range(0, stall_max);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            check_result(out_ch.drive_force, out_ch.in_dead_band);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[pid_position_force] ERROR");
            $finish;
        end
    end

    // Reset values, error wrap, most negative error, windup and derivative wrap
    task automatic test_default_settings();
        send_position(16'sd0, 16'sd0);
        send_position(16'sd0, 16'sd99);
        send_position(16'sd0, 16'sd100);
        send_position(16'sd100, 16'sd0);
        send_position(16'sd0, 16'sd30000);
        send_position(16'sd30000, 16'sd0);
        send_position(-16'sd32768, 16'sd0);
        send_position(16'sd0, -16'sd32768);
        send_position(-16'sd32768, 16'sd32767);
        send_position(16'sd32767, -16'sd32768);
        send_position(16'sh5555, -16'sh5556);
    endtask

    // Register extremes, zero band, masked band bits, limit shrink, gain clear
    task automatic test_register_writes();
        t_cfg_addr idx;
        cfg_write(CFG_PROP_GAIN, 16'h7FFF);
        cfg_write(CFG_INTEG_GAIN, 16'h8000);
        cfg_write(CFG_DERIV_GAIN, 16'h0000);
        cfg_write(CFG_DEAD_BAND, 16'h0000);
        cfg_write(CFG_INTEGRAL_LIMIT, 16'h0000);
        send_position(16'sd0, 16'sd0);
        send_position(16'sd0, 16'sd1000);
        send_position(16'sd0, -16'sd1000);
        // Top data bit is not part of the band or the limit
        cfg_write(CFG_DEAD_BAND, 16'hFFFF);
        cfg_write(CFG_INTEGRAL_LIMIT, 16'hFFFF);
        send_position(16'sd0, 16'sd32767);
        send_position(16'sd0, -16'sd32767);
        send_position(16'sd0, 16'sd32766);
        // Band and limit writes keep the loop state
        cfg_write(CFG_PROP_GAIN, 16'h8000);
        cfg_write(CFG_INTEG_GAIN, 16'd41);
        cfg_write(CFG_DERIV_GAIN, 16'h7FFF);
        cfg_write(CFG_DEAD_BAND, 16'd10);
        send_position(16'sd0, 16'sd5000);
        send_position(16'sd0, 16'sd5000);
        cfg_write(CFG_INTEGRAL_LIMIT, 16'd50);
        send_position(16'sd0, 16'sd200);
        // Writes to unused indexes change nothing
        for (idx = CFG_SPARE_LO; ; idx++) begin
            cfg_write(idx, 16'hFFFF);
            if (idx == CFG_SPARE_HI) break;
        end
        send_position(16'sd0, 16'sd200);
        // A gain write clears the loop state
        cfg_write(CFG_PROP_GAIN, 16'd410);
        send_position(16'sd0, 16'sd200);
        send_position(-16'sd200, 16'sd0);
    endtask

    // Receiver holds off while the sender keeps going, then the sender pauses
    task automatic test_backpressure();
        int k;
        send_gap_max = 0;
        hold_request = 80;
        for (k = 0; k < 40; k++)
            send_position(t_pos'($urandom_range(0, 65535)), t_pos'($urandom_range(0, 65535)));
        drain_results();
        send_gap_max = MAX_WAIT;
        for (k = 0; k < 10; k++)
            send_position(t_pos'($urandom_range(0, 800)), t_pos'($urandom_range(0, 800)));
    endtask

    function automatic t_cfg_data pick_gain();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3, 4: return t_cfg_data'($urandom_range(0, 65535));
            default: return t_cfg_data'(int'($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    function automatic t_cfg_data pick_range();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return t_cfg_data'($urandom_range(0, 65535));
            default: return t_cfg_data'($urandom_range(0, 1500));
        endcase
    endfunction

    // Random phases, each with fresh settings and its own idling pattern
    task automatic test_random_tracking();
        int phase;
        int k;
        int e;
        int span;
        t_pos meas;
        for (phase = 0; phase < PHASES; phase++) begin
            cfg_write(CFG_DEAD_BAND, pick_range());
            cfg_write(CFG_INTEGRAL_LIMIT, pick_range());
            cfg_write(CFG_PROP_GAIN, pick_gain());
            cfg_write(CFG_INTEG_GAIN, pick_gain());
            cfg_write(CFG_DERIV_GAIN, pick_gain());
            if ($urandom_range(0, 3) == 0)
                cfg_write(t_cfg_addr'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                          t_cfg_data'($urandom_range(0, 65535)));
            send_gap_max = (phase % 3 == 0) ? 0 : MAX_WAIT;
            stall_max = (phase % 3 == 1) ? 0 : MAX_WAIT;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                meas = t_pos'($urandom_range(0, 65535));
                case ($urandom_range(0, 9))
                    // Errors around the dead band edge
                    0, 1, 2, 3, 4, 5: begin
                        span = int'(band) + 32;
                        e = int'($urandom_range(0, 2 * span)) - span;
                    end
                    6, 7: e = int'($urandom_range(0, 4096)) - 2048;
                    default: e = int'($urandom_range(0, 65535));
                endcase
                send_position(meas, meas + t_pos'(e));
            end
        end
        send_gap_max = MAX_WAIT;
        stall_max = MAX_WAIT;
    endtask

    // Sequence of tests
    initial begin
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.measured_position <= '0;
        in_ch.wanted_position <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data <= '0;
        send_gap_max = MAX_WAIT;
        stall_max = MAX_WAIT;
        reset_controller();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_settings();
        test_register_writes();
        test_backpressure();
        test_random_tracking();

        drain_results();
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
        $display("Covered %0d position items and %0d register writes;", items_sent, reg_writes);
        $display("%0d results checked, %0d of them inside the dead band.",
                 results_seen, band_hits);
        if (mismatches == 0)
            $display("[pid_position_force] OK");
        else
            $display("[pid_position_force] ERROR");
        $finish;
    end

endmodule
